// File: rtl/bbc_pkg.sv
`timescale 1ns / 1ps

package bbc_pkg;

    localparam int STACK_DEPTH     = 1024;
    localparam int STACK_ADDR_BITS = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STACK_CNT_BITS  = $clog2(STACK_DEPTH + 1);
    localparam int LINE_BITS       = 16;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam int NUM_KINDS = 3;

    typedef logic [1:0] kind_t;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_LINE_COMMENT,
        MODE_BLOCK_COMMENT,
        MODE_LITERAL
    } scan_mode_t;

    typedef enum logic [1:0] {
        ST_BALANCED,
        ST_UNEXPECTED,
        ST_MISMATCH,
        ST_UNCLOSED
    } status_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
    } text_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] fault_line;
        logic [7:0]  found_char;
        logic [7:0]  expected_closer;
        logic [7:0]  opener_char;
        logic [15:0] opener_line;
    } result_req_t;

    typedef struct packed {
        logic  push;
        logic  close;
        kind_t kind;
    } scan_action_t;

    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic                 clear;
        kind_t                kind;
        logic [LINE_BITS-1:0] line;
    } stack_cmd_t;

    typedef struct packed {
        logic                 nonempty;
        kind_t                kind;
        logic [LINE_BITS-1:0] line;
    } stack_view_t;

    typedef struct packed {
        kind_t                kind;
        logic [LINE_BITS-1:0] line;
    } stack_entry_t;

    localparam int ENTRY_BITS = $bits(stack_entry_t);

    function automatic logic [7:0] opener_byte(input kind_t k);
        logic [7:0] b;
        unique case (k)
            2'd0:    b = CH_LPAREN;
            2'd1:    b = CH_LBRACK;
            2'd2:    b = CH_LBRACE;
            default: b = CH_LPAREN;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] closer_byte(input kind_t k);
        logic [7:0] b;
        unique case (k)
            2'd0:    b = CH_RPAREN;
            2'd1:    b = CH_RBRACK;
            2'd2:    b = CH_RBRACE;
            default: b = CH_RPAREN;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] quote_byte(input kind_t k);
        logic [7:0] b;
        unique case (k)
            2'd0:    b = CH_DQUOTE;
            2'd1:    b = CH_SQUOTE;
            2'd2:    b = CH_BTICK;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/bbc_ram.sv
`timescale 1ns / 1ps

module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/bbc_scanner.sv
`timescale 1ns / 1ps

module bbc_scanner
    import bbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           text_byte,
    input  logic                 advance,
    input  logic                 clear,
    output scan_action_t         action,
    output logic [LINE_BITS-1:0] line
);

    scan_mode_t           mode_reg, mode_next;
    kind_t                quote_kind_reg, quote_kind_next;
    logic                 escape_pending_reg, escape_pending_next;
    logic                 slash_pending_reg, slash_pending_next;
    logic                 star_pending_reg, star_pending_next;
    logic [LINE_BITS-1:0] line_reg, line_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_NORMAL;
            quote_kind_reg     <= '0;
            escape_pending_reg <= 1'b0;
            slash_pending_reg  <= 1'b0;
            star_pending_reg   <= 1'b0;
            line_reg           <= LINE_ONE;
        end
        else if (clear)
        begin
            mode_reg           <= MODE_NORMAL;
            quote_kind_reg     <= '0;
            escape_pending_reg <= 1'b0;
            slash_pending_reg  <= 1'b0;
            star_pending_reg   <= 1'b0;
            line_reg           <= LINE_ONE;
        end
        else if (advance)
        begin
            mode_reg           <= mode_next;
            quote_kind_reg     <= quote_kind_next;
            escape_pending_reg <= escape_pending_next;
            slash_pending_reg  <= slash_pending_next;
            star_pending_reg   <= star_pending_next;
            line_reg           <= line_next;
        end
    end

    always_comb
    begin
        logic done;
        logic hit;
        done                = 1'b0;
        hit                 = 1'b0;
        mode_next           = mode_reg;
        quote_kind_next     = quote_kind_reg;
        escape_pending_next = escape_pending_reg;
        slash_pending_next  = slash_pending_reg;
        star_pending_next   = star_pending_reg;
        line_next           = line_reg;
        action              = '0;

        // a pending slash either opens a comment or falls through
        if (slash_pending_reg)
        begin
            slash_pending_next = 1'b0;
            if (text_byte == CH_SLASH)
            begin
                mode_next = MODE_LINE_COMMENT;
                done      = 1'b1;
            end
            else if (text_byte == CH_STAR)
            begin
                mode_next = MODE_BLOCK_COMMENT;
                done      = 1'b1;
            end
        end

        if (!done && star_pending_reg)
        begin
            star_pending_next = 1'b0;
            if (text_byte == CH_SLASH)
            begin
                mode_next = MODE_NORMAL;
                done      = 1'b1;
            end
        end

        // escaped byte is swallowed, line feed included
        if (!done && escape_pending_reg)
        begin
            escape_pending_next = 1'b0;
            done                = 1'b1;
        end

        if (!done && text_byte == CH_LF)
        begin
            if (line_reg != LINE_MAX)
            begin
                line_next = line_reg + LINE_ONE;
            end
            if (mode_reg == MODE_LINE_COMMENT)
            begin
                mode_next = MODE_NORMAL;
            end
            done = 1'b1;
        end

        if (!done)
        begin
            unique case (mode_reg)
                MODE_LINE_COMMENT:
                begin
                end
                MODE_BLOCK_COMMENT:
                begin
                    if (text_byte == CH_STAR)
                    begin
                        star_pending_next = 1'b1;
                    end
                end
                MODE_LITERAL:
                begin
                    if (text_byte == CH_BSLASH)
                    begin
                        escape_pending_next = 1'b1;
                    end
                    else if (quote_kind_reg != 2'd3 &&
                             text_byte == quote_byte(quote_kind_reg))
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_NORMAL:
                begin
                    if (text_byte == CH_SLASH)
                    begin
                        slash_pending_next = 1'b1;
                    end
                    else
                    begin
                        for (int k = 0; k < NUM_KINDS; k++)
                        begin
                            if (!hit && text_byte == quote_byte(kind_t'(k)))
                            begin
                                mode_next       = MODE_LITERAL;
                                quote_kind_next = kind_t'(k);
                                hit             = 1'b1;
                            end
                        end
                        for (int k = 0; k < NUM_KINDS; k++)
                        begin
                            if (!hit && text_byte == opener_byte(kind_t'(k)))
                            begin
                                action.push = 1'b1;
                                action.kind = kind_t'(k);
                                hit         = 1'b1;
                            end
                            if (!hit && text_byte == closer_byte(kind_t'(k)))
                            begin
                                action.close = 1'b1;
                                action.kind  = kind_t'(k);
                                hit          = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign line = line_reg;

endmodule

// File: rtl/bbc_stack.sv
`timescale 1ns / 1ps

module bbc_stack
    import bbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  stack_cmd_t  cmd,
    output stack_view_t top,
    output stack_view_t top_after
);

    logic [STACK_CNT_BITS-1:0]  count_reg, count_next, count_op;
    kind_t                      top_kind_reg, top_kind_op;
    logic [LINE_BITS-1:0]       top_line_reg, top_line_op;
    logic                       do_push;
    logic [STACK_ADDR_BITS-1:0] raddr;
    stack_entry_t               wentry, below;

    // the top entry lives in registers; the RAM keeps reading the entry under it
    assign do_push = cmd.push && (count_reg != STACK_CNT_BITS'(STACK_DEPTH));

    always_comb
    begin
        count_op    = count_reg;
        top_kind_op = top_kind_reg;
        top_line_op = top_line_reg;
        if (do_push)
        begin
            count_op    = count_reg + STACK_CNT_BITS'(1);
            top_kind_op = cmd.kind;
            top_line_op = cmd.line;
        end
        else if (cmd.pop)
        begin
            count_op    = count_reg - STACK_CNT_BITS'(1);
            top_kind_op = below.kind;
            top_line_op = below.line;
        end
        count_next = cmd.clear ? '0 : count_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_kind_reg <= top_kind_op;
        top_line_reg <= top_line_op;
    end

    assign raddr       = STACK_ADDR_BITS'(count_next - STACK_CNT_BITS'(2));
    assign wentry.kind = cmd.kind;
    assign wentry.line = cmd.line;

    bbc_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (count_reg[STACK_ADDR_BITS-1:0]),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (below)
    );

    assign top.nonempty       = (count_reg != '0);
    assign top.kind           = top_kind_reg;
    assign top.line           = top_line_reg;
    assign top_after.nonempty = (count_op != '0);
    assign top_after.kind     = top_kind_op;
    assign top_after.line     = top_line_op;

endmodule

// File: rtl/bracket_balance_checker_unit.sv
`timescale 1ns / 1ps

// Bracket balance checker: takes one text byte per cycle on the text channel
// and, on the byte marked last, registers one result for the result channel
// (in the skid entry while the result register is held), then starts the
// next text from a clean state. The top of the bracket stack is held in
// registers and the stack RAM is read one entry below it every cycle, so one
// write and one read port sustain a push or pop on every byte. Two result
// registers decouple the channels; text_ready drops only while both hold
// results that have not been taken. No clearing pass is needed after reset.
module bracket_balance_checker_unit
    import bbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_ready,
    input  text_req_t   text_req,
    output logic        result_valid,
    input  logic        result_ready,
    output result_req_t result_req
);

    logic                 accept, advance, last_acc;
    scan_action_t         action;
    logic [LINE_BITS-1:0] line;
    stack_cmd_t           cmd;
    stack_view_t          top, top_after;
    logic                 close_hit, unexpected, mismatch, new_err;

    logic                 err_valid_reg, err_valid_next;
    status_t              err_status_reg;
    logic [LINE_BITS-1:0] err_line_reg;
    logic [7:0]           err_found_reg;
    kind_t                err_kind_reg;
    logic [LINE_BITS-1:0] err_oline_reg;

    status_t              eff_status;
    logic [LINE_BITS-1:0] eff_line, eff_oline;
    logic [7:0]           eff_found;
    kind_t                eff_kind;
    result_req_t          res;

    logic                 result_valid_reg, result_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    result_req_t          result_reg, result_next, skid_reg, skid_next;
    logic                 out_take;

    assign accept   = text_valid && text_ready;
    assign advance  = accept && !err_valid_reg;
    assign last_acc = accept && text_req.is_last;

    bbc_scanner u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_byte (text_req.text_byte),
        .advance   (advance),
        .clear     (last_acc),
        .action    (action),
        .line      (line)
    );

    assign close_hit  = advance && action.close;
    assign unexpected = close_hit && !top.nonempty;
    assign mismatch   = close_hit && top.nonempty && (top.kind != action.kind);
    assign new_err    = unexpected || mismatch;

    assign cmd.push  = advance && action.push;
    assign cmd.pop   = close_hit && top.nonempty && (top.kind == action.kind);
    assign cmd.clear = last_acc;
    assign cmd.kind  = action.kind;
    assign cmd.line  = line;

    bbc_stack u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .top       (top),
        .top_after (top_after)
    );

    // latch the first bad closer; later bytes wait for the last one
    always_comb
    begin
        err_valid_next = err_valid_reg || new_err;
        if (last_acc)
        begin
            err_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_valid_reg <= 1'b0;
        end
        else
        begin
            err_valid_reg <= err_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (new_err)
        begin
            err_status_reg <= unexpected ? ST_UNEXPECTED : ST_MISMATCH;
            err_line_reg   <= line;
            err_found_reg  <= text_req.text_byte;
            err_kind_reg   <= top.kind;
            err_oline_reg  <= top.line;
        end
    end

    always_comb
    begin
        if (err_valid_reg)
        begin
            eff_status = err_status_reg;
            eff_line   = err_line_reg;
            eff_found  = err_found_reg;
            eff_kind   = err_kind_reg;
            eff_oline  = err_oline_reg;
        end
        else
        begin
            eff_status = unexpected ? ST_UNEXPECTED : ST_MISMATCH;
            eff_line   = line;
            eff_found  = text_req.text_byte;
            eff_kind   = top.kind;
            eff_oline  = top.line;
        end

        res = '0;
        if (err_valid_reg || new_err)
        begin
            res.status     = eff_status;
            res.fault_line = 16'(eff_line);
            res.found_char = eff_found;
            if (eff_status == ST_MISMATCH)
            begin
                res.expected_closer = closer_byte(eff_kind);
                res.opener_char     = opener_byte(eff_kind);
                res.opener_line     = 16'(eff_oline);
            end
        end
        else if (top_after.nonempty)
        begin
            res.status          = ST_UNCLOSED;
            res.fault_line      = 16'(top_after.line);
            res.expected_closer = closer_byte(top_after.kind);
            res.opener_char     = opener_byte(top_after.kind);
            res.opener_line     = 16'(top_after.line);
        end
    end

    // result register plus one skid entry
    assign out_take   = result_valid_reg && result_ready;
    assign text_ready = !skid_valid_reg;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        skid_valid_next   = skid_valid_reg;
        result_next       = result_reg;
        skid_next         = skid_reg;
        priority if (skid_valid_reg)
        begin
            if (out_take)
            begin
                result_next     = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (last_acc)
        begin
            if (!result_valid_reg || out_take)
            begin
                result_next       = res;
                result_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        skid_reg   <= skid_next;
    end

    assign result_valid = result_valid_reg;
    assign result_req   = result_reg;

    a_skid_implies_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid entry held while result register empty");

    a_last_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        last_acc |=> result_valid_reg)
        else $error("last byte accepted without a result");

    a_last_clears_error: assert property (
        @(posedge clk) disable iff (!rst_n)
        last_acc |=> !err_valid_reg)
        else $error("error latch not cleared after last byte");

    a_no_stack_op_after_error: assert property (
        @(posedge clk) disable iff (!rst_n)
        err_valid_reg |-> !cmd.push && !cmd.pop)
        else $error("stack changed after an error was latched");

endmodule
